// ----- hdl/spq_pkg.sv -----
package spq_pkg;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // operation applied to every cell in the row this cycle
  typedef struct packed {
    logic enq;
    logic deq;
  } op_t;

  // what a cell shows its right-hand neighbour
  typedef struct packed {
    logic valid;
    logic gt;     // holds an entry whose priority is above the incoming one
  } link_t;

endpackage

// ----- hdl/spq_in_if.sv -----
interface spq_in_if #(
  parameter int EW = 16,
  parameter int PW = 16
) ();
  logic          valid;
  logic          ready;
  logic          action;
  logic [EW-1:0] elem_in;
  logic [PW-1:0] prio_in;

  modport source (output valid, action, elem_in, prio_in, input ready);
  modport sink   (input valid, action, elem_in, prio_in, output ready);
endinterface

// ----- hdl/spq_out_if.sv -----
interface spq_out_if #(
  parameter int EW = 16,
  parameter int PW = 16,
  parameter int CW = 5
) ();
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [EW-1:0] head_elem;
  logic [PW-1:0] head_prio;
  logic [CW-1:0] occupancy;
  logic          is_empty;

  modport source (output valid, status, head_elem, head_prio, occupancy, is_empty,
                  input ready);
  modport sink   (input valid, status, head_elem, head_prio, occupancy, is_empty,
                  output ready);
endinterface

// ----- hdl/spq_cell.sv -----
module spq_cell #(
  parameter int EW = 16,
  parameter int PW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::op_t   op,
  input  logic [EW-1:0]  new_elem,
  input  logic [PW-1:0]  new_prio,
  input  spq_pkg::link_t left,
  input  logic [EW-1:0]  left_elem,
  input  logic [PW-1:0]  left_prio,
  input  logic           right_valid,
  input  logic [EW-1:0]  right_elem,
  input  logic [PW-1:0]  right_prio,
  output spq_pkg::link_t link,
  output logic [EW-1:0]  elem,
  output logic [PW-1:0]  prio
);
  import spq_pkg::*;

  logic valid;
  logic take_new;

  // strict compare: equal priorities stay ahead of the newcomer
  assign link.valid = valid;
  assign link.gt    = valid && (prio > new_prio);

  // sorted row: the newcomer lands in the first slot that is free or larger,
  // provided the left side is full and not itself shifting right
  assign take_new = (link.gt || !valid) && left.valid && !left.gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.enq) begin
      valid <= valid || left.valid;
    end else if (op.deq) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.enq) begin
      if (left.gt) begin
        elem <= left_elem;
        prio <= left_prio;
      end else if (take_new) begin
        elem <= new_elem;
        prio <= new_prio;
      end
    end else if (op.deq) begin
      elem <= right_elem;
      prio <= right_prio;
    end
  end

endmodule

// ----- hdl/stable_sorted_priority_queue.sv -----
// Sorted priority queue, smallest priority value at the head.
//
// Channels: "in" carries requests (action 0 = enqueue elem_in/prio_in,
// action 1 = dequeue the head); "out" returns one result per request with
// the status, the head after the request, the occupancy and an empty flag.
// A request is taken when valid and ready are both high at a clock edge.
//
// Storage is a row of CAPACITY cells kept in ascending order. On enqueue
// every cell compares its priority with the incoming one in parallel and
// either holds, takes its left neighbour's entry or takes the new entry;
// on dequeue every cell takes its right neighbour's entry. Equal priorities
// therefore leave in arrival order.
//
// The result is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver takes each result; the row is updated as the request is taken.
// Enqueue on a full queue reports ST_FULL, dequeue on an empty one
// ST_EMPTY, and neither changes the contents.
// A synchronous reset empties the queue and drops any pending result.
// A stalled receiver holds the result register; in.ready falls until the
// pending result is taken, so no request is lost.
module stable_sorted_priority_queue #(
  parameter int CAPACITY  = 16,
  parameter int ELEM_BITS = 16,
  parameter int PRIO_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  spq_in_if.sink    in,
  spq_out_if.source out
);
  import spq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic                 accept;
  logic                 full;
  logic                 empty;
  op_t                  op;
  logic [CntW-1:0]      cnt;
  logic [1:0]           status;
  logic                 res_valid;

  link_t                lnk    [CAPACITY];
  logic [ELEM_BITS-1:0] c_elem [CAPACITY];
  logic [PRIO_BITS-1:0] c_prio [CAPACITY];

  // result register frees up as soon as the receiver takes it
  assign in.ready = !res_valid || out.ready;
  assign accept   = in.valid && in.ready;

  assign full  = (cnt == CntW'(CAPACITY));
  assign empty = (cnt == '0);

  assign op.enq = accept && !in.action && !full;
  assign op.deq = accept &&  in.action && !empty;

  // row of cells; the head sits at index 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    link_t                left;
    logic [ELEM_BITS-1:0] left_elem;
    logic [PRIO_BITS-1:0] left_prio;
    logic                 right_valid;
    logic [ELEM_BITS-1:0] right_elem;
    logic [PRIO_BITS-1:0] right_prio;

    if (g == 0) begin : g_head
      // virtual full slot in front of the head that never shifts
      assign left      = '{valid: 1'b1, gt: 1'b0};
      assign left_elem = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left      = lnk[g-1];
      assign left_elem = c_elem[g-1];
      assign left_prio = c_prio[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_elem  = '0;
      assign right_prio  = '0;
    end else begin : g_body
      assign right_valid = lnk[g+1].valid;
      assign right_elem  = c_elem[g+1];
      assign right_prio  = c_prio[g+1];
    end

    spq_cell #(
      .EW (ELEM_BITS),
      .PW (PRIO_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_elem    (in.elem_in),
      .new_prio    (in.prio_in),
      .left        (left),
      .left_elem   (left_elem),
      .left_prio   (left_prio),
      .right_valid (right_valid),
      .right_elem  (right_elem),
      .right_prio  (right_prio),
      .link        (lnk[g]),
      .elem        (c_elem[g]),
      .prio        (c_prio[g])
    );
  end

  // occupancy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (op.enq) begin
      cnt <= cnt + 1'b1;
    end else if (op.deq) begin
      cnt <= cnt - 1'b1;
    end
  end

  // result handshake and status
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in.action && empty) begin
        status <= ST_EMPTY;
      end else if (!in.action && full) begin
        status <= ST_FULL;
      end else begin
        status <= ST_DONE;
      end
    end
  end

  // head is read straight from the row and count from the occupancy counter; they only
  // move on a taken request, which also reloads the result register
  assign out.valid     = res_valid;
  assign out.status    = status;
  assign out.head_elem = lnk[0].valid ? c_elem[0] : '0;
  assign out.head_prio = lnk[0].valid ? c_prio[0] : '0;
  assign out.occupancy = cnt;
  assign out.is_empty  = empty;

endmodule

// ----- hdl/spq_checker.sv -----
module spq_checker #(
  parameter int CAPACITY = 16,
  parameter int CW       = 5
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [1:0]    out_status,
  input logic [CW-1:0] out_occupancy,
  input logic          out_is_empty
);
  import spq_pkg::*;

  // a taken request always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request taken without a result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_EMPTY) |-> out_is_empty)
    else $error("empty status on a non-empty queue");

  a_enq_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_FULL) |-> (out_occupancy == CW'(CAPACITY)))
    else $error("full status on a queue that is not full");

endmodule

bind stable_sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY),
  .CW       ($clog2(CAPACITY + 1))
) u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in.valid),
  .in_ready      (in.ready),
  .out_valid     (out.valid),
  .out_ready     (out.ready),
  .out_status    (out.status),
  .out_occupancy (out.occupancy),
  .out_is_empty  (out.is_empty)
);

// ----- bench/spq_checker.sv -----
`timescale 1ns / 100ps

package spq_bench_pkg;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

endpackage

module spq_scoreboard
  import spq_pkg::*;
  import spq_bench_pkg::*;
(
  input  logic clk,
  input  logic rst,
  spq_in_if    requests,
  spq_out_if   results,
  output int   errors,
  output int   pending
);

  localparam int DEPTH      = 16;
  localparam int PRINT_CAP  = 200;

  typedef struct packed {
    logic [15:0] elem;
    logic [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] head_elem;
    logic [15:0] head_prio;
    logic [4:0]  occupancy;
    logic        is_empty;
  } head_report_t;

  entry_t       sorted_row[$];      // predicted contents, head at index 0
  head_report_t expected_heads[$];
  int           error_count = 0;

  // applies one request to the predicted row, returns the report it should give
  function automatic head_report_t apply_request(logic act, logic [15:0] elem,
                                                 logic [15:0] prio);
    head_report_t rep;
    entry_t       fresh;
    int           pos;
    rep.status = ST_DONE;
    if (act == ACT_ENQUEUE) begin
      if (sorted_row.size() >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        fresh.elem = elem;
        fresh.prio = prio;
        // behind every entry of equal or smaller priority
        pos = 0;
        while (pos < sorted_row.size() && sorted_row[pos].prio <= prio) pos++;
        sorted_row.insert(pos, fresh);
      end
    end else if (sorted_row.size() == 0) begin
      rep.status = ST_EMPTY;
    end else begin
      void'(sorted_row.pop_front());
    end
    rep.occupancy = 5'(sorted_row.size());
    rep.is_empty  = (sorted_row.size() == 0);
    rep.head_elem = rep.is_empty ? 16'h0000 : sorted_row[0].elem;
    rep.head_prio = rep.is_empty ? 16'h0000 : sorted_row[0].prio;
    return rep;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("%0t spq_scoreboard: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    head_report_t want;
    if (rst) begin
      sorted_row.delete();
      expected_heads.delete();
    end else begin
      // a result always belongs to an earlier request, so check before predicting
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        if (expected_heads.size() == 0) begin
          report_mismatch("result with no request pending", results.occupancy, 0);
        end else begin
          want = expected_heads.pop_front();
          if (results.status !== want.status)
            report_mismatch("status", results.status, want.status);
          if (results.head_elem !== want.head_elem)
            report_mismatch("head_elem", results.head_elem, want.head_elem);
          if (results.head_prio !== want.head_prio)
            report_mismatch("head_prio", results.head_prio, want.head_prio);
          if (results.occupancy !== want.occupancy)
            report_mismatch("occupancy", results.occupancy, want.occupancy);
          if (results.is_empty !== want.is_empty)
            report_mismatch("is_empty", results.is_empty, want.is_empty);
        end
      end
      if (requests.valid === 1'b1 && requests.ready === 1'b1)
        expected_heads.push_back(apply_request(requests.action, requests.elem_in,
                                               requests.prio_in));
    end
    errors  <= error_count;
    pending <= expected_heads.size();
  end

endmodule

// ----- bench/tb_stable_sorted_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_stable_sorted_priority_queue;
  import spq_pkg::*;
  import spq_bench_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int RANDOM_REQUESTS = 1400;
  localparam int HOLD_CYCLES     = 80;      // long receiver hold-off
  localparam int CYCLE_LIMIT     = 500_000; // well over the slowest clean run

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   errors;
  int   pending;
  // sender asks for a receiver hold-off by bumping hold_asks; receiver answers
  int   hold_asks    = 0;
  int   holds_served = 0;

  spq_in_if  #(.EW(16), .PW(16))          req_ch ();
  spq_out_if #(.EW(16), .PW(16), .CW(5))  res_ch ();

  stable_sorted_priority_queue #(
    .CAPACITY  (CAPACITY),
    .ELEM_BITS (16),
    .PRIO_BITS (16)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .in  (req_ch),
    .out (res_ch)
  );

  // predicts and compares; hands back its mismatch count and outstanding results
  spq_scoreboard i_checker (
    .clk      (clk),
    .rst      (rst),
    .requests (req_ch),
    .results  (res_ch),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // guard against a hung handshake
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_stable_sorted_priority_queue: done, errors");
    $finish;
  end

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // priorities: a narrow band for plenty of ties, the extremes, or anything
  function automatic logic [15:0] pick_prio();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // leaves valid high on return, so a follow-on request needs no toggle
  task automatic send_request(action_e act, logic [15:0] elem, logic [15:0] prio);
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.elem_in <= elem;
    req_ch.prio_in <= prio;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering until every predicted result has been returned
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: ready in runs of random length with random stalls between,
  // some runs long enough to give unbroken stretches. A pending hold-off
  // request takes priority and drops ready.
  initial begin : receiver
    int run;
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_asks != holds_served) begin
        holds_served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        run = ($urandom_range(3) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    action_e     act;
    int          sent;
    int          burst;
    int          burst_len;
    int          mode;
    int          enq_pct;
    bit          quiet;
    logic [15:0] tie_prio[3];

    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.action  <= ACT_ENQUEUE;
    req_ch.elem_in <= 16'h0000;
    req_ch.prio_in <= 16'h0000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // dequeue with nothing stored; payload at its extremes, must be ignored
    send_request(ACT_DEQUEUE, 16'hFFFF, 16'hFFFF);
    idle_sender(pick_gap());
    // largest priority first, then the smallest takes over the head
    send_request(ACT_ENQUEUE, 16'hFFFF, 16'hFFFF);
    send_request(ACT_ENQUEUE, 16'h0000, 16'h0000);
    // equal priority at the head: must queue behind, head unchanged
    send_request(ACT_ENQUEUE, 16'h0001, 16'h0000);
    idle_sender(pick_gap());
    // equal priority at the tail
    send_request(ACT_ENQUEUE, 16'h0002, 16'hFFFF);
    // fill to capacity with a few repeated priorities in the middle
    tie_prio = '{16'h8000, 16'h0001, 16'h7FFF};
    for (int i = 4; i < CAPACITY; i++) begin
      send_request(ACT_ENQUEUE, 16'h1000 + 16'(i), tie_prio[i % 3]);
      idle_sender(pick_gap());
    end
    // enqueue on full: dropped, even though its priority equals the head's
    send_request(ACT_ENQUEUE, 16'h5A5A, 16'h0000);
    send_request(ACT_DEQUEUE, 16'h0000, 16'h0000);
    send_request(ACT_DEQUEUE, 16'hFFFF, 16'hFFFF);
    send_request(ACT_DEQUEUE, 16'h0000, 16'h0000);
    send_request(ACT_ENQUEUE, 16'hC3C3, 16'h0001);
    wait_drained();

    // --- random part ---
    // bursts that mostly fill, mostly drain or mix, so both full and empty
    // are hit often and the row is reordered at every depth
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(30, 4);
      mode      = $urandom_range(2);
      enq_pct   = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      quiet     = ($urandom_range(3) == 0);
      if (burst % 9 == 4) begin
        // receiver holds off while requests keep coming: the block backs up
        hold_asks++;
        quiet = 1'b1;
      end
      for (int k = 0; k < burst_len; k++) begin
        act = ($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
        send_request(act, 16'($urandom()), pick_prio());
        sent++;
        if (!quiet) idle_sender(pick_gap());
      end
      if (burst % 11 == 7) wait_drained();
      burst++;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("tb_stable_sorted_priority_queue: done, clean");
    else
      $display("tb_stable_sorted_priority_queue: done, errors");
    $finish;
  end

endmodule
